// File: sv/tdp_pkg.sv
// Shared types for the trial-division primality tester.
// No dependencies; imported by the top level.
package tdp_pkg;

  // Sequencer states of the tester.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_DECIDE,
    ST_FINISH
  } tdp_state_t;

  // Smallest divisor tried, and its square.
  localparam int unsigned FIRST_DIVISOR = 2;
  localparam int unsigned FIRST_SQUARE  = FIRST_DIVISOR * FIRST_DIVISOR;

endpackage : tdp_pkg

// File: sv/trial_division_prime_test_top.sv
// Top level of the trial-division primality tester.
// Depends on tdp_pkg for the sequencer state type and the first divisor.

// One candidate is taken per beat and tested by trying divisors 2, 3, 4, ...
// while divisor squared does not exceed the candidate; the first divisor
// that leaves no remainder marks it composite. Each trial divisor compares
// the running square against the candidate, runs a bit-serial restoring
// remainder over the NUM_WIDTH bits of the candidate and then inspects the
// remainder. At most floor(sqrt(candidate)) - 1 divisors are tried. One
// candidate is worked on at a time; the next one is accepted as soon as the
// previous verdict has moved into the output register, even if that result
// is still stalled. A finished verdict waits in its last step for as long as
// the output register still holds an untaken beat.
// Only the low NUM_WIDTH bits of candidate are used, and tested_value echoes
// the candidate after that masking.
module trial_division_prime_test_top #(
  parameter int unsigned NUM_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [15:0] candidate,
  input  logic        in_valid,
  output logic        in_stall,
  output logic        is_prime,
  output logic [15:0] tested_value,
  output logic        out_valid,
  input  logic        out_stall
);
  import tdp_pkg::*;

  // Divisor width: large enough for 2**ceil(NUM_WIDTH/2).
  localparam int unsigned DW = (NUM_WIDTH + 1) / 2 + 1;
  // Running square of the divisor never exceeds 2**(NUM_WIDTH+1) - 1.
  localparam int unsigned SW = NUM_WIDTH + 1;
  // Bit counter of the serial remainder.
  localparam int unsigned CW = $clog2(NUM_WIDTH);

  tdp_state_t            state, state_next;
  logic [NUM_WIDTH-1:0]  n, n_next;
  logic [NUM_WIDTH-1:0]  shreg, shreg_next;
  logic [DW-1:0]         d, d_next;
  logic [SW-1:0]         sq, sq_next;
  logic [DW-1:0]         rem, rem_next;
  logic [CW-1:0]         cnt, cnt_next;
  logic                  verdict, verdict_next;

  logic [NUM_WIDTH-1:0]  n_load;
  logic [DW:0]           rem_shift;
  logic [DW:0]           rem_diff;
  logic                  out_free;
  logic                  out_load;

  // Candidate masked to the working width.
  assign n_load    = NUM_WIDTH'(candidate);
  // One step of the restoring remainder: bring in the next bit of n.
  assign rem_shift = {rem, shreg[NUM_WIDTH-1]};
  assign rem_diff  = rem_shift - {1'b0, d};

  assign out_free = !out_valid || !out_stall;
  assign out_load = (state == ST_FINISH) && out_free;
  assign in_stall = (state != ST_IDLE);

  // State register and datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
    n       <= n_next;
    shreg   <= shreg_next;
    d       <= d_next;
    sq      <= sq_next;
    rem     <= rem_next;
    cnt     <= cnt_next;
    verdict <= verdict_next;
  end

  // Sequencer: next state and datapath updates.
  always_comb begin
    state_next   = state;
    n_next       = n;
    shreg_next   = shreg;
    d_next       = d;
    sq_next      = sq;
    rem_next     = rem;
    cnt_next     = cnt;
    verdict_next = verdict;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          n_next = n_load;
          d_next = DW'(FIRST_DIVISOR);
          sq_next = SW'(FIRST_SQUARE);
          if (n_load < NUM_WIDTH'(FIRST_DIVISOR)) begin
            // Zero and one are not prime.
            verdict_next = 1'b0;
            state_next   = ST_FINISH;
          end else begin
            state_next = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (sq > SW'(n)) begin
          // No divisor up to the square root divides n.
          verdict_next = 1'b1;
          state_next   = ST_FINISH;
        end else begin
          shreg_next = n;
          rem_next   = '0;
          cnt_next   = CW'(NUM_WIDTH - 1);
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (rem_shift >= {1'b0, d}) begin
          rem_next = DW'(rem_diff);
        end else begin
          rem_next = DW'(rem_shift);
        end
        shreg_next = shreg << 1;
        if (cnt == '0) begin
          state_next = ST_DECIDE;
        end else begin
          cnt_next = cnt - CW'(1);
        end
      end
      ST_DECIDE: begin
        if (rem == '0) begin
          verdict_next = 1'b0;
          state_next   = ST_FINISH;
        end else begin
          // (d+1)^2 = d^2 + 2d + 1
          d_next     = d + DW'(1);
          sq_next    = sq + SW'({d, 1'b0}) + SW'(1);
          state_next = ST_CHECK;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Output register: holds the verdict beat until it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (out_load) begin
      is_prime     <= verdict;
      tested_value <= 16'(n);
    end
  end

endmodule : trial_division_prime_test_top

// File: sv/tdp_checker.sv
// Port-level checks for the trial-division primality tester.
// Depends only on the top level's ports; bound to it at the end of the file.
module tdp_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        is_prime,
  input logic [15:0] tested_value,
  input logic        out_valid,
  input logic        out_stall
);

  // A stalled result beat stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

  // A stalled result beat keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(is_prime) && $stable(tested_value))
    else $error("result payload changed while stalled");

  // One candidate at a time: after an accepted beat the input is stalled.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second candidate accepted while busy");

  // Nothing below two is reported prime.
  a_small: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_prime |-> tested_value >= 16'd2)
    else $error("zero or one reported prime");

  // The only even prime is two.
  a_even: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_prime && !tested_value[0] |-> tested_value == 16'd2)
    else $error("even number above two reported prime");

endmodule : tdp_checker

bind trial_division_prime_test_top tdp_checker u_tdp_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .is_prime     (is_prime),
  .tested_value (tested_value),
  .out_valid    (out_valid),
  .out_stall    (out_stall)
);

// File: dv/trial_division_prime_test_top_tb.sv
// Self-checking testbench for the trial-division primality tester.
// Depends on tdp_pkg and trial_division_prime_test_top; holds its own verdict predictor.
module trial_division_prime_test_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tdp_pkg::*;

  localparam int unsigned NUM_WIDTH   = 16;
  localparam logic [15:0] VALUE_MASK  = (NUM_WIDTH >= 16) ? 16'hFFFF
                                        : 16'((32'd1 << NUM_WIDTH) - 1);
  localparam int          QUIET_LIMIT = 40000;
  localparam int          HOLD_CYCLES = 400;
  localparam int          RANDOM_ITEMS = 110;

  // Expected verdict for one candidate.
  typedef struct packed {
    logic        prime;
    logic [15:0] value;
  } verdict_t;

  // One row of the directed table; typed rows carry their verdict.
  typedef struct {
    logic [15:0] value;
    bit          typed;
    logic        prime;
  } directed_row_t;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic [15:0] candidate = '0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  logic        is_prime;
  logic [15:0] tested_value;
  logic        out_valid;
  logic        out_stall = 1'b0;

  verdict_t verdict_q[$];
  int       mismatches  = 0;
  int       n_sent      = 0;
  int       n_checked   = 0;
  int       n_primes    = 0;
  int       quiet_count = 0;
  int       hold_len    = 0;
  bit       no_idle     = 1'b0;

  trial_division_prime_test_top #(
    .NUM_WIDTH (NUM_WIDTH)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .candidate    (candidate),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .is_prime     (is_prime),
    .tested_value (tested_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall)
  );

  always #5 clk = ~clk;

  // Verdict by trial division up to the square root of the candidate.
  function automatic logic trial_divide_prime(input logic [15:0] n);
    int unsigned d;
    if (n < FIRST_DIVISOR) return 1'b0;
    for (d = FIRST_DIVISOR; d * d <= n; d++) begin
      if (n % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Smallest prime at or above start, falling back to the largest 16-bit prime.
  function automatic logic [15:0] next_prime_from(input int unsigned start);
    int unsigned n;
    for (n = start; n <= 65535; n++) begin
      if (trial_divide_prime(16'(n))) return 16'(n);
    end
    return 16'd65521;
  endfunction

  // Random candidate: mostly small and quick, some primes and prime squares that
  // run the divisor loop to its end, and a few from the full range.
  function automatic logic [15:0] pick_candidate();
    int unsigned r;
    logic [15:0] p;
    r = $urandom_range(0, 99);
    if (r < 25) return 16'($urandom_range(0, 255));
    if (r < 55) return 16'($urandom_range(0, 4095));
    if (r < 75) return next_prime_from($urandom_range(0, 4095));
    if (r < 85) begin
      p = next_prime_from($urandom_range(2, 251));
      return 16'(p * p);
    end
    if (r < 95) return 16'($urandom());
    return next_prime_from($urandom_range(0, 65535));
  endfunction

  // Offer one beat after a random gap, or none while no_idle is set, and record its verdict once accepted.
  task automatic offer_candidate(input logic [15:0] value, input bit typed,
                                 input logic typed_prime);
    int       gap;
    verdict_t v;
    gap = no_idle ? 0 : $urandom_range(0, 8);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    candidate <= value;
    in_valid  <= 1'b1;
    do @(posedge clk); while (in_stall);
    v.value = value & VALUE_MASK;
    v.prime = typed ? typed_prime : trial_divide_prime(v.value);
    verdict_q.push_back(v);
    n_sent++;
  endtask

  // Withdraw the input and wait for every outstanding verdict.
  task automatic drain_verdicts();
    @(negedge clk);
    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
  endtask

  // Receiver: random stalls per beat (none while no_idle is set), or a long hold-off when one is requested.
  initial begin
    int wait_n;
    wait (rst == 1'b0);
    forever begin
      @(negedge clk);
      if (hold_len > 0) begin
        wait_n   = hold_len;
        hold_len = 0;
      end else if (no_idle) begin
        wait_n = 0;
      end else begin
        wait_n = $urandom_range(0, 8);
      end
      if (wait_n > 0) begin
        out_stall <= 1'b1;
        repeat (wait_n) @(negedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
    end
  end

  // Compare each accepted result beat with the oldest expected verdict.
  always @(posedge clk) begin
    verdict_t exp_v;
    if (!rst && out_valid && !out_stall) begin
      if (verdict_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: result with nothing pending: is_prime=%0b tested_value=%0d",
                   is_prime, tested_value);
      end else begin
        exp_v = verdict_q.pop_front();
        if (is_prime !== exp_v.prime || tested_value !== exp_v.value) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"ERROR: expected is_prime=%0b tested_value=%0d, ",
                      "got is_prime=%0b tested_value=%0d"},
                     exp_v.prime, exp_v.value, is_prime, tested_value);
        end
        n_checked++;
        if (exp_v.prime) n_primes++;
      end
    end
  end

  // Watchdog on cycles in which neither side moves a beat.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_count = 0;
    end else begin
      quiet_count++;
      if (quiet_count >= QUIET_LIMIT) begin
        $display("Timeout after %0d quiet cycles, %0d verdicts outstanding",
                 quiet_count, verdict_q.size());
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Stimulus sequence.
  initial begin
    directed_row_t rows[$];
    rows = '{
      '{16'd0,     1'b1, 1'b0},  // zero is not prime
      '{16'd1,     1'b1, 1'b0},  // one is not prime
      '{16'd2,     1'b1, 1'b1},  // two is prime with no divisor tried
      '{16'd3,     1'b1, 1'b1},
      '{16'd4,     1'b1, 1'b0},  // smallest square: divisor equals root
      '{16'd5,     1'b1, 1'b1},
      '{16'd9,     1'b0, 1'b0},
      '{16'd25,    1'b0, 1'b0},
      '{16'd49,    1'b0, 1'b0},
      '{16'd97,    1'b0, 1'b0},
      '{16'd121,   1'b0, 1'b0},
      '{16'd255,   1'b0, 1'b0},
      '{16'd7919,  1'b0, 1'b0},
      '{16'd63001, 1'b0, 1'b0},  // square of 251, found at the last divisor
      '{16'd65519, 1'b0, 1'b0},
      '{16'd65521, 1'b1, 1'b1},  // largest 16-bit prime, full divisor sweep
      '{16'd65534, 1'b1, 1'b0},
      '{16'd65535, 1'b1, 1'b0},  // all bits set
      '{16'h8000,  1'b1, 1'b0},  // top bit alone
      '{16'h5555,  1'b0, 1'b0},
      '{16'hAAAA,  1'b1, 1'b0},
      '{16'hFF00,  1'b1, 1'b0},
      '{16'd2,     1'b1, 1'b1}
    };

    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // Directed table.
    foreach (rows[i]) offer_candidate(rows[i].value, rows[i].typed, rows[i].prime);
    drain_verdicts();

    // Long receiver hold-off while quick candidates keep coming, so the input stalls.
    hold_len = HOLD_CYCLES;
    repeat (8) offer_candidate(16'($urandom_range(0, 99)), 1'b0, 1'b0);
    drain_verdicts();

    // Random candidates, with one stretch free of idling and a mid-run drain.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      no_idle = (i >= 40 && i < 60);
      if (i == 90) drain_verdicts();
      offer_candidate(pick_candidate(), 1'b0, 1'b0);
    end
    no_idle = 1'b0;
    drain_verdicts();
    repeat (32) @(posedge clk);

    $display("Tested %0d candidates (directed table, input back-pressure, random mix);",
             n_sent);
    $display("%0d verdicts checked, %0d of them prime.", n_checked, n_primes);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule : trial_division_prime_test_top_tb

// File: filelist.f
sv/tdp_pkg.sv
sv/trial_division_prime_test_top.sv
sv/tdp_checker.sv
dv/trial_division_prime_test_top_tb.sv
